// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the window pooling top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off during reset
`define WP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("window pooling check failed");

// implication checked in the cycle after the condition
`define WP_ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("window pooling sequence check failed");

`endif

// ===== rtl/core/wpool_pkg.sv =====
// types and constants of the window pooling block
`default_nettype none
package wpool_pkg;

   localparam int OUT_W  = 22;
   localparam int AREA_W = 8;
   localparam int ROW_W  = 12;

   localparam logic [1:0] MODE_SUM  = 2'd0;
   localparam logic [1:0] MODE_MAX  = 2'd1;
   localparam logic [1:0] MODE_MEAN = 2'd2;

   localparam logic [3:0] CSR_POOL_MODE     = 4'd0;
   localparam logic [3:0] CSR_FILTER_HEIGHT = 4'd1;
   localparam logic [3:0] CSR_FILTER_WIDTH  = 4'd2;
   localparam logic [3:0] CSR_STRIDE_ROWS   = 4'd3;
   localparam logic [3:0] CSR_STRIDE_COLS   = 4'd4;
   localparam logic [3:0] CSR_FRAME_HEIGHT  = 4'd5;
   localparam logic [3:0] CSR_FRAME_WIDTH   = 4'd6;
   localparam logic [3:0] CSR_CHANNEL_COUNT = 4'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DIV_GO,
      ST_DIV_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [3:0]       ph;
      logic [ROW_W-1:0] idx;
   } phase_type;

endpackage
`default_nettype wire

// ===== rtl/core/wpool_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module wpool_div import wpool_pkg::*; #(
   parameter int DW = 22,
   parameter int VW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff;
   logic [VW:0]   rem_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [VW:0]   rem_shift, rem_new;
   logic          fits;

   always_comb begin
      rem_shift = {rem_ff[VW-1:0], quo_ff[DW-1]};
      fits      = rem_shift >= {1'b0, divisor};
      rem_new   = fits ? rem_shift - {1'b0, divisor} : rem_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], fits};
         rem_ff <= rem_new;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/core/window_pooling_2d.sv =====
// top level of the two-dimensional window pooling block
// usage:
//   req channel: one signed q8.8 sample per word, row, column, channel order,
//   frames back to back. a word is taken when req_valid is high and req_stall
//   is low.
//   rsp channel: one pooled word per completed window, held in an output
//   register until rsp_stall is low; the next sample is taken meanwhile.
//   csr channel: register writes, always ready; a write to indices 0 to 7 restarts the frame.
// sequence:
//   a sample that completes no window does not stall the req channel.
//   a sample that completes a window stalls req while the block reads each
//   window entry from the ring through the single read port, then drains,
//   then in mean mode runs the shared bit-serial divider on a dividend of
//   sample bits + log2 of the largest filter area + 1 bits, then loads.
//   result leaves the output register the cycle after the load at earliest.
// reset: synchronous, clears positions and the handshake state and loads
//   the default registers; the ring store is not cleared, a window only reads
//   entries written earlier in the same frame.
// stall: a stalled result holds; the block finishes the next window but waits
//   in its load state until the output register is free.
`default_nettype none
`include "assert_macros.svh"
module window_pooling_2d import wpool_pkg::*; #(
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_FILTER   = 8,
   parameter int SAMPLE_BITS  = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [OUT_W-1:0]            rsp_pooled_value,
   output logic [ROW_W-1:0]            rsp_out_row,
   output logic [5:0]                  rsp_out_col,
   output logic [3:0]                  rsp_out_channel,
   output logic                        rsp_frame_last,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [3:0]             csr_index,
   input  wire logic [12:0]            csr_data
);
   localparam int DEPTH = MAX_FILTER * MAX_WIDTH * MAX_CHANNELS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
   localparam int ACC_W = SAMPLE_BITS + $clog2(MAX_FILTER * MAX_FILTER) + 1;
   localparam int WIDE  = (ACC_W > OUT_W) ? ACC_W : OUT_W;

   // configuration registers
   logic [1:0]  mode_ff;
   logic [3:0]  fh_ff, fw_ff, sr_ff, sc_ff;
   logic [12:0] hh_ff;
   logic [6:0]  ww_ff;
   logic [4:0]  cc_ff;

   // effective (clamped) settings
   logic [3:0]  fh, fw, sr, sc;
   logic [12:0] hh;
   logic [6:0]  ww;
   logic [4:0]  cc;

   // stream position and window phase tracking
   logic [ROW_W-1:0] row_ff, row_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [6:0]       col_ff, col_in;
   logic [4:0]       chan_ff, chan_in;
   phase_type        rph_ff, rph_in, cph_ff, cph_in;

   // current window job
   logic [4:0]       job_ch_ff;
   logic [6:0]       job_c0_ff;
   logic [ROW_W-1:0] job_orow_ff, job_ocol_ff;
   logic             job_last_ff;
   logic [SW-1:0]    slot0;
   logic [SW:0]      slot0_tmp;

   // window walk
   logic [SW-1:0] rd_slot_ff;
   logic [3:0]    wi_ff, wj_ff;
   logic          pending_ff, pending_in;
   logic          walk_last;

   // ring store
   logic [SAMPLE_BITS-1:0] ring_ff [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [6:0]             rd_col;

   // accumulation
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [SAMPLE_BITS-1:0] best_ff;
   logic                          first_ff;

   // divider and result
   logic              div_start, div_done;
   logic [ACC_W-1:0]  div_mag, div_quo;
   logic [AREA_W-1:0] area;
   logic signed [ACC_W-1:0] res_acc;
   logic signed [WIDE-1:0]  res_wide;

   state_type state_ff, state_in;
   logic      accept, win_hit, load_rsp, csr_write;
   logic      rsp_valid_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign accept    = req_valid && !req_stall;

   // clamp settings, zero counts as one
   always_comb begin
      fh = (fh_ff == 4'd0) ? 4'd1 : (int'(fh_ff) > MAX_FILTER ? 4'(MAX_FILTER) : fh_ff);
      fw = (fw_ff == 4'd0) ? 4'd1 : (int'(fw_ff) > MAX_FILTER ? 4'(MAX_FILTER) : fw_ff);
      sr = (sr_ff == 4'd0) ? 4'd1 : sr_ff;
      sc = (sc_ff == 4'd0) ? 4'd1 : sc_ff;
      hh = (hh_ff == 13'd0) ? 13'd1 : (hh_ff > 13'd4096 ? 13'd4096 : hh_ff);
      ww = (ww_ff == 7'd0) ? 7'd1 : (int'(ww_ff) > MAX_WIDTH ? 7'(MAX_WIDTH) : ww_ff);
      cc = (cc_ff == 5'd0) ? 5'd1 : (int'(cc_ff) > MAX_CHANNELS ? 5'(MAX_CHANNELS) : cc_ff);
      area = AREA_W'(fh) * AREA_W'(fw);
   end

   // phase within the stride once the window fits, and output index
   function automatic phase_type next_phase(input logic [12:0] pnew, input logic [3:0] f,
                                            input logic [3:0] s, input phase_type cur);
      phase_type nx;
      nx = cur;
      if (pnew + 13'd1 <= {9'd0, f}) begin
         nx.ph  = 4'd0;
         nx.idx = '0;
      end else if ({1'b0, cur.ph} + 5'd1 == {1'b0, s}) begin
         nx.ph  = 4'd0;
         nx.idx = cur.idx + ROW_W'(1);
      end else begin
         nx.ph = cur.ph + 4'd1;
      end
      return nx;
   endfunction

   always_comb begin
      win_hit = ({1'b0, row_ff} + 13'd1 >= {9'd0, fh}) && (col_ff + 7'd1 >= {3'd0, fw})
                && (rph_ff.ph == 4'd0) && (cph_ff.ph == 4'd0);
      slot0_tmp = {1'b0, slot_ff} + (SW+1)'(MAX_FILTER) - (SW+1)'(fh - 4'd1);
      if (int'(slot0_tmp) >= MAX_FILTER) slot0_tmp = slot0_tmp - (SW+1)'(MAX_FILTER);
      slot0 = slot0_tmp[SW-1:0];
   end

   // position advance, channel fastest
   always_comb begin
      row_in  = row_ff;
      slot_in = slot_ff;
      col_in  = col_ff;
      chan_in = chan_ff;
      rph_in  = rph_ff;
      cph_in  = cph_ff;
      if (chan_ff + 5'd1 >= cc) begin
         chan_in = 5'd0;
         if (col_ff + 7'd1 >= ww) begin
            col_in = 7'd0;
            if ({1'b0, row_ff} + 13'd1 >= hh) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               slot_in = ({1'b0, slot_ff} + (SW+1)'(1) == (SW+1)'(MAX_FILTER)) ? '0
                         : slot_ff + SW'(1);
            end
            rph_in = next_phase({1'b0, row_in}, fh, sr, rph_ff);
         end else begin
            col_in = col_ff + 7'd1;
         end
         cph_in = next_phase({6'd0, col_in}, fw, sc, cph_ff);
      end else begin
         chan_in = chan_ff + 5'd1;
      end
   end

   // configuration and position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MAX;
         fh_ff   <= 4'd2;
         fw_ff   <= 4'd2;
         sr_ff   <= 4'd2;
         sc_ff   <= 4'd2;
         hh_ff   <= 13'd64;
         ww_ff   <= 7'd64;
         cc_ff   <= 5'd1;
         row_ff  <= '0;
         slot_ff <= '0;
         col_ff  <= '0;
         chan_ff <= '0;
         rph_ff  <= '0;
         cph_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POOL_MODE:     mode_ff <= csr_data[1:0];
            CSR_FILTER_HEIGHT: fh_ff   <= csr_data[3:0];
            CSR_FILTER_WIDTH:  fw_ff   <= csr_data[3:0];
            CSR_STRIDE_ROWS:   sr_ff   <= csr_data[3:0];
            CSR_STRIDE_COLS:   sc_ff   <= csr_data[3:0];
            CSR_FRAME_HEIGHT:  hh_ff   <= csr_data;
            CSR_FRAME_WIDTH:   ww_ff   <= csr_data[6:0];
            CSR_CHANNEL_COUNT: cc_ff   <= csr_data[4:0];
            default: ;
         endcase
         // any write to indices 0 to 7 restarts the frame
         if (csr_index <= CSR_CHANNEL_COUNT) begin
            row_ff  <= '0;
            slot_ff <= '0;
            col_ff  <= '0;
            chan_ff <= '0;
            rph_ff  <= '0;
            cph_ff  <= '0;
         end
      end else if (accept) begin
         row_ff  <= row_in;
         slot_ff <= slot_in;
         col_ff  <= col_in;
         chan_ff <= chan_in;
         rph_ff  <= rph_in;
         cph_ff  <= cph_in;
      end
   end

   // ring store, one write and one registered read per cycle
   assign rd_col  = job_c0_ff + {3'd0, wj_ff};
   assign wr_addr = AW'((int'(slot_ff) * MAX_WIDTH + int'(col_ff)) * MAX_CHANNELS
                        + int'(chan_ff));
   assign rd_addr = AW'((int'(rd_slot_ff) * MAX_WIDTH + int'(rd_col)) * MAX_CHANNELS
                        + int'(job_ch_ff));

   always_ff @(posedge clock) begin
      if (accept) ring_ff[wr_addr] <= req_sample;
      rd_data_ff <= ring_ff[rd_addr];
   end

   // job capture and window walk
   assign walk_last = ({1'b0, wi_ff} + 5'd1 == {1'b0, fh}) &&
                      ({1'b0, wj_ff} + 5'd1 == {1'b0, fw});

   always_ff @(posedge clock) begin
      if (accept && win_hit) begin
         job_ch_ff   <= chan_ff;
         job_c0_ff   <= col_ff + 7'd1 - {3'd0, fw};
         job_orow_ff <= rph_ff.idx;
         job_ocol_ff <= cph_ff.idx;
         job_last_ff <= ({1'b0, row_ff} + 13'd1 + {9'd0, sr} > hh) &&
                        ({1'b0, col_ff} + 8'd1 + {4'd0, sc} > {1'b0, ww}) &&
                        (chan_ff + 5'd1 == cc);
         rd_slot_ff  <= slot0;
         wi_ff       <= 4'd0;
         wj_ff       <= 4'd0;
      end else if (state_ff == ST_READ) begin
         if ({1'b0, wj_ff} + 5'd1 == {1'b0, fw}) begin
            wj_ff      <= 4'd0;
            wi_ff      <= wi_ff + 4'd1;
            rd_slot_ff <= ({1'b0, rd_slot_ff} + (SW+1)'(1) == (SW+1)'(MAX_FILTER)) ? '0
                          : rd_slot_ff + SW'(1);
         end else begin
            wj_ff <= wj_ff + 4'd1;
         end
      end
   end

   // accumulate sum and maximum as read data returns
   always_ff @(posedge clock) begin
      if (accept && win_hit) begin
         acc_ff   <= '0;
         first_ff <= 1'b1;
      end else if (pending_ff) begin
         acc_ff   <= acc_ff + ACC_W'(signed'(rd_data_ff));
         first_ff <= 1'b0;
         if (first_ff || signed'(rd_data_ff) > best_ff) best_ff <= signed'(rd_data_ff);
      end
   end

   // shared divider for the mean, on the magnitude
   assign div_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   wpool_div #(
      .DW(ACC_W),
      .VW(AREA_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .divisor  (area),
      .done     (div_done),
      .quotient (div_quo)
   );

   // result select
   always_comb begin
      case (mode_ff)
         MODE_MAX:  res_acc = ACC_W'(best_ff);
         MODE_MEAN: res_acc = acc_ff[ACC_W-1] ? -signed'(div_quo) : signed'(div_quo);
         default:   res_acc = acc_ff;
      endcase
      res_wide = WIDE'(res_acc);
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept && win_hit) state_in = ST_READ;
         ST_READ:    if (walk_last) state_in = ST_DRAIN;
         ST_DRAIN:   state_in = (mode_ff == MODE_MEAN) ? ST_DIV_GO : ST_DONE;
         ST_DIV_GO:  state_in = ST_DIV_RUN;
         ST_DIV_RUN: if (div_done) state_in = ST_DONE;
         ST_DONE:    if (load_rsp) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      pending_in = (state_ff == ST_READ);
      div_start  = (state_ff == ST_DIV_GO);
      load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_pooled_value <= res_wide[OUT_W-1:0];
         rsp_out_row      <= job_orow_ff;
         rsp_out_col      <= job_ocol_ff[5:0];
         rsp_out_channel  <= job_ch_ff[3:0];
         rsp_frame_last   <= job_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `WP_ASSERT_NEXT(a_read_returns, state_ff == ST_READ, pending_ff)
   `WP_ASSERT(a_div_done_in_run, !div_done || state_ff == ST_DIV_RUN)
   `WP_ASSERT_NEXT(a_hit_starts_walk, accept && win_hit, state_ff == ST_READ)
   `WP_ASSERT_NEXT(a_load_waits, state_ff == ST_DONE && rsp_valid_ff && rsp_stall,
                   state_ff == ST_DONE)
endmodule
`default_nettype wire

// ===== tb/window_pooling_2d_test.sv =====
// self-checking testbench for the window pooling block with its own pooling predictor
`default_nettype none
module window_pooling_2d_test;
   import wpool_pkg::*;

   localparam int RING_DEPTH = 8 * 64 * 16;
   localparam int SETTLE = 150;       // covers the slowest window incl. mean divide
   localparam int WATCHDOG = 5000;    // idle cycles with no word moving anywhere

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic [ROW_W-1:0] row;
      logic [5:0]       col;
      logic [3:0]       chan;
      logic             last;
   } pooled_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_W-1:0] rsp_pooled_value;
   logic [ROW_W-1:0] rsp_out_row;
   logic [5:0] rsp_out_col;
   logic [3:0] rsp_out_channel;
   logic rsp_frame_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_index = '0;
   logic [12:0] csr_data = '0;

   window_pooling_2d u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pooled_value(rsp_pooled_value), .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col), .rsp_out_channel(rsp_out_channel),
      .rsp_frame_last(rsp_frame_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block: registers as written, positions and ring store
   logic [1:0]  cfg_mode;
   logic [3:0]  cfg_fh, cfg_fw, cfg_sr, cfg_sc;
   logic [12:0] cfg_height;
   logic [6:0]  cfg_width;
   logic [4:0]  cfg_chans;
   int pos_row, pos_col, pos_chan;
   logic signed [15:0] ring [RING_DEPTH];

   logic [15:0]     pending_samples [$];
   pooled_word_type expected_pool [$];

   int mismatches = 0;
   int samples_sent = 0;
   int words_checked = 0;
   int phases_run = 0;
   int idle_count = 0;
   int send_idle = 0;     // percent of cycles the sender holds off
   int recv_idle = 0;     // percent of cycles the receiver stalls
   logic sample_taken = 1'b0;
   logic word_moved;

   function automatic int clamp(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int ring_slot(int r, int c, int ch);
      return (((r % 8) * 64 + c) * 16 + ch) % RING_DEPTH;
   endfunction

   task automatic apply_register(logic [3:0] idx, logic [12:0] data);
      case (idx)
         CSR_POOL_MODE:     cfg_mode = data[1:0];
         CSR_FILTER_HEIGHT: cfg_fh = data[3:0];
         CSR_FILTER_WIDTH:  cfg_fw = data[3:0];
         CSR_STRIDE_ROWS:   cfg_sr = data[3:0];
         CSR_STRIDE_COLS:   cfg_sc = data[3:0];
         CSR_FRAME_HEIGHT:  cfg_height = data;
         CSR_FRAME_WIDTH:   cfg_width = data[6:0];
         CSR_CHANNEL_COUNT: cfg_chans = data[4:0];
         default: return;   // unknown index leaves everything alone
      endcase
      pos_row = 0;
      pos_col = 0;
      pos_chan = 0;
   endtask

   // store the sample and, if it closes a window, queue the pooled word
   task automatic predict_window(logic [15:0] raw);
      int fh, fw, sr, sc, hh, ww, cc, r, c, ch, r0, c0, acc, best, v, area;
      pooled_word_type w;
      fh = clamp(cfg_fh, 8);
      fw = clamp(cfg_fw, 8);
      sr = (cfg_sr == 0) ? 1 : cfg_sr;
      sc = (cfg_sc == 0) ? 1 : cfg_sc;
      hh = clamp(cfg_height, 4096);
      ww = clamp(cfg_width, 64);
      cc = clamp(cfg_chans, 16);
      r = pos_row;
      c = pos_col;
      ch = pos_chan;
      if (r >= hh || c >= ww || ch >= cc) begin
         r = 0;
         c = 0;
         ch = 0;
      end
      ring[ring_slot(r, c, ch)] = raw;
      if (r + 1 >= fh && c + 1 >= fw && (r + 1 - fh) % sr == 0 && (c + 1 - fw) % sc == 0) begin
         r0 = r + 1 - fh;
         c0 = c + 1 - fw;
         acc = 0;
         best = ring[ring_slot(r0, c0, ch)];
         for (int i = 0; i < fh; i++) begin
            for (int j = 0; j < fw; j++) begin
               v = ring[ring_slot(r0 + i, c0 + j, ch)];
               acc += v;
               if (v > best) best = v;
            end
         end
         area = fh * fw;
         if (cfg_mode == MODE_MAX) w.value = best[OUT_W-1:0];
         else if (cfg_mode == MODE_MEAN) w.value = 22'(acc / area);   // truncates toward zero
         else w.value = acc[OUT_W-1:0];                                 // sum, also unused mode
         w.row = 12'(r0 / sr);
         w.col = 6'(c0 / sc);
         w.chan = 4'(ch);
         w.last = (r0 / sr == (hh - fh) / sr) && (c0 / sc == (ww - fw) / sc) && (ch + 1 == cc);
         expected_pool.push_back(w);
      end
      ch++;
      if (ch >= cc) begin
         ch = 0;
         c++;
         if (c >= ww) begin
            c = 0;
            r++;
            if (r >= hh) r = 0;
         end
      end
      pos_row = r;
      pos_col = c;
      pos_chan = ch;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %0s: got %0d want %0d (word %0d)", what, got, want, words_checked);
      mismatches++;
   endtask

   // driver: sample word and receiver stall change on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || sample_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
               req_sample <= pending_samples.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
      sample_taken <= 1'b0;
   end

   // monitor: everything is sampled on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         word_moved = 1'b0;
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            word_moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            predict_window(req_sample);
            samples_sent <= samples_sent + 1;
            sample_taken <= 1'b1;
            word_moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            word_moved = 1'b1;
            if (expected_pool.size() == 0) begin
               report_mismatch("unexpected word at row", int'(rsp_out_row), -1);
            end else begin
               pooled_word_type w;
               w = expected_pool.pop_front();
               if (rsp_pooled_value !== w.value)
                  report_mismatch("value", $signed(rsp_pooled_value), $signed(w.value));
               if (rsp_out_row !== w.row) report_mismatch("row", rsp_out_row, w.row);
               if (rsp_out_col !== w.col) report_mismatch("col", rsp_out_col, w.col);
               if (rsp_out_channel !== w.chan)
                  report_mismatch("channel", rsp_out_channel, w.chan);
               if (rsp_frame_last !== w.last)
                  report_mismatch("frame_last", rsp_frame_last, w.last);
            end
            words_checked <= words_checked + 1;
         end
         idle_count <= word_moved ? 0 : idle_count + 1;
         if (idle_count >= WATCHDOG) begin
            $display("watchdog: nothing moved for %0d cycles", WATCHDOG);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // write a full register set, then one random index beyond the end of the map
   task automatic write_all(int mode, int fh, int fw, int sr, int sc, int hh, int ww, int cc);
      logic [12:0] vals [8];
      vals = '{13'(mode), 13'(fh), 13'(fw), 13'(sr), 13'(sc), 13'(hh), 13'(ww), 13'(cc)};
      for (int i = 0; i < 9; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= (i < 8) ? 4'(i) : 4'($urandom_range(8, 15));
         csr_data <= (i < 8) ? vals[i] : 13'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every sample went in and every pooled word came out
   task automatic drain;
      while (pending_samples.size() != 0 || req_valid || expected_pool.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      phases_run++;
   endtask

   task automatic pick_idling;
      if (samples_sent < 250) begin
         send_idle = 14;
         recv_idle = 71;
      end else if (samples_sent < 450) begin
         send_idle = 71;
         recv_idle = 14;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++)
         pending_samples.push_back(16'($urandom));
   endtask

   initial begin
      int hh, ww, cc, fh, fw, n;
      cfg_mode = MODE_MAX;
      cfg_fh = 4'd2;
      cfg_fw = 4'd2;
      cfg_sr = 4'd2;
      cfg_sc = 4'd2;
      cfg_height = 13'd64;
      cfg_width = 7'd64;
      cfg_chans = 5'd1;
      pos_row = 0;
      pos_col = 0;
      pos_chan = 0;
      foreach (ring[i]) ring[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      pick_idling();

      // reset defaults: a 2x2 max over the first two rows of a wide frame
      for (int i = 0; i < 128; i++)
         pending_samples.push_back((i % 3 == 0) ? 16'h8000 : 16'($urandom));
      drain();

      // directed: extreme samples through sum, max, mean on a 4x4 frame
      for (int m = 0; m < 3; m++) begin
         write_all(m, 2, 2, 2, 2, 4, 4, 1);
         for (int i = 0; i < 16; i++)
            pending_samples.push_back((i % 4 == 0) ? 16'h7fff : (i % 4 == 1) ? 16'h8000 :
                                      (i % 4 == 2) ? 16'hffff : 16'h0000);
         drain();
      end
      // unused mode, zero filter, stride and frame sizes: every sample is a window
      write_all(3, 0, 0, 0, 0, 0, 0, 0);
      queue_random(4);
      drain();
      // oversize filter and frame bounds clamp to their limits
      write_all(MODE_MEAN, 15, 15, 1, 1, 8, 8, 1);
      for (int i = 0; i < 64; i++) pending_samples.push_back(16'h8000);
      drain();
      write_all(MODE_SUM, 1, 1, 8, 8, 8191, 127, 31);
      queue_random(40);
      drain();
      // frame smaller than the filter gives nothing
      write_all(MODE_MAX, 4, 4, 1, 1, 3, 3, 1);
      queue_random(9);
      drain();

      // random configurations with small frames, one or two frames each, capped at 150 samples
      while (samples_sent < 650) begin
         pick_idling();
         fh = $urandom_range(1, 8);
         fw = $urandom_range(1, 8);
         hh = $urandom_range(fh, fh + 6);
         ww = $urandom_range(fw, fw + 8);
         cc = $urandom_range(1, 4);
         if ($urandom_range(9) == 0) cc = 16;
         write_all($urandom_range(0, 3), fh, fw, $urandom_range(1, 8), $urandom_range(1, 8),
                   hh, ww, cc);
         n = hh * ww * cc * $urandom_range(1, 2);
         if (n > 150) n = 150;
         queue_random(n);
         drain();
      end

      $display("covered %0d phases, %0d samples in, %0d pooled words checked",
               phases_run, samples_sent, words_checked);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
